/* hw/rtl/sorted_multiset_store_macros.svh */
// assertion helpers for the sorted multiset store
`ifndef SORTED_MULTISET_STORE_MACROS_SVH
`define SORTED_MULTISET_STORE_MACROS_SVH

// checked only outside reset
`define SMS_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define SMS_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sms_pkg.sv */
package sms_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_COUNT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] occurrences;
    logic [4:0] size_now;
    logic       is_empty;
    logic       is_full;
  } out_item_t;

  // per-item control broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
    logic descending;
  } cell_ctl_t;

  // what travels down the tally pipeline beside the match flags
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic       ins_ok;
    logic       rem_ok;
    logic [4:0] size_now;
    logic       is_empty;
    logic       is_full;
  } tally_head_t;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] REG_ORDER_ADDR = 3'd0;

  localparam int GROUP_BITS = 8;

endpackage

/* hw/rtl/sms_cell.sv */
module sms_cell #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  sms_pkg::cell_ctl_t           ctl,
  input  logic                         occupied,
  input  logic signed [VALUE_BITS-1:0] key,
  input  logic signed [VALUE_BITS-1:0] left_val,
  input  logic signed [VALUE_BITS-1:0] right_val,
  input  logic                         ins_before_in,
  input  logic                         rem_found_in,
  output logic                         ins_before_out,
  output logic                         rem_found_out,
  output logic                         match,
  output logic signed [VALUE_BITS-1:0] val
);
  import sms_pkg::*;

  logic goes_before;
  logic hit;

  assign goes_before = ctl.descending ? (key >= val) : (key <= val);
  // an empty cell always takes the key if nothing ahead did
  assign hit            = !occupied || goes_before;
  assign match          = occupied && (val == key);
  assign ins_before_out = ins_before_in || hit;
  assign rem_found_out  = rem_found_in || match;

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (ins_before_in) begin
        val <= left_val;
      end else if (hit) begin
        val <= key;
      end
    end else if (ctl.rem_en && rem_found_out) begin
      val <= right_val;
    end
  end

endmodule

/* hw/rtl/sms_tally.sv */
module sms_tally #(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [CAPACITY-1:0]   flags,
  input  sms_pkg::tally_head_t  head,
  output logic                  res_valid,
  output sms_pkg::out_item_t    res
);
  import sms_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int NG     = (CAPACITY + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GW     = $clog2(GROUP_BITS + 1);
  localparam int PADDED = NG * GROUP_BITS;

  logic [PADDED-1:0] flags_q;
  tally_head_t       head1;
  logic [GW-1:0]     grp_q [NG];
  tally_head_t       head2;

  logic [PADDED-1:0] flags_pad;
  logic [GW-1:0]     grp_sum [NG];
  logic [CW-1:0]     total;
  logic [CW-1:0]     occ_full;
  logic [CW+4:0]     occ_wide;

  assign flags_pad = PADDED'(flags);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_sum[g] = '0;
      for (int b = 0; b < GROUP_BITS; b++) begin
        grp_sum[g] = grp_sum[g] + GW'(flags_q[g*GROUP_BITS + b]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NG; g++) begin
      total = total + CW'(grp_q[g]);
    end
    occ_full = total + CW'(head2.ins_ok) - CW'(head2.rem_ok);
    occ_wide = (CW + 5)'(occ_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head1.valid <= 1'b0;
      head2.valid <= 1'b0;
      res_valid   <= 1'b0;
    end else if (advance) begin
      flags_q <= flags_pad;
      head1   <= head;
      grp_q   <= grp_sum;
      head2   <= head1;
      res_valid <= head2.valid;
      res.occurrences <= occ_wide[4:0];
      res.size_now    <= head2.size_now;
      res.is_empty    <= head2.is_empty;
      res.is_full     <= head2.is_full;
      unique case (head2.kind)
        KIND_INSERT: res.ok <= head2.ins_ok;
        KIND_REMOVE: res.ok <= head2.rem_ok;
        default:     res.ok <= (total != '0);
      endcase
    end
  end

endmodule

/* hw/rtl/sorted_multiset_store.sv */
// channel   signals                          direction  moves
// in        in_valid, in_stall, in_data      into block one item: kind, value
// out       out_valid, out_stall, out_data   from block one result per item
// cfg       psel, penable, pwrite, paddr...  into block order_descending at 0x0
//
// one item a cycle while no result is held; each result comes out of the registered tally
// the chain of cells inserts or removes in the cycle the item is taken
// the copy count goes through a registered tally (flag, group-sum and result registers) behind the chain
// a stalled result freezes the tally pipeline and stalls the input
// rst clears the element count, the order and the pipeline valids
module sorted_multiset_store #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sms_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sms_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sms_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [sms_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [sms_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import sms_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                         order_descending;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [CW+4:0]                size_wide;

  logic                         advance;
  logic                         accept;
  logic                         ins_ok;
  logic                         rem_ok;
  logic signed [63:0]           key_ext;
  logic signed [VALUE_BITS-1:0] key;
  cell_ctl_t                    ctl;
  tally_head_t                  head;

  logic [CAPACITY-1:0]          occupied;
  logic [CAPACITY-1:0]          match;
  logic [CAPACITY:0]            ins_before;
  logic [CAPACITY:0]            rem_found;
  logic signed [VALUE_BITS-1:0] vals [CAPACITY];

  // config port, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ORDER_ADDR) ? APB_DATA_BITS'(order_descending) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_descending <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == REG_ORDER_ADDR)) begin
      order_descending <= pwdata[0];
    end
  end

  // the whole pipeline moves unless a result is held
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // sign-extend, then wrap to the stored width
  assign key_ext = 64'(in_data.value);
  assign key     = key_ext[VALUE_BITS-1:0];

  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    unique case (in_data.kind)
      KIND_INSERT: ins_ok = accept && (count < CW'(CAPACITY));
      KIND_REMOVE: rem_ok = accept && rem_found[CAPACITY];
      default: begin
      end
    endcase
  end

  assign ctl.ins_en     = ins_ok;
  assign ctl.rem_en     = accept && (in_data.kind == KIND_REMOVE);
  assign ctl.descending = order_descending;

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + 1'b1;
    end else if (rem_ok) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // cell chain: insert flag ripples right, remove flag ripples right,
  // values shift toward the tail on insert and toward the head on remove
  assign ins_before[0] = 1'b0;
  assign rem_found[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] left_val;
    logic signed [VALUE_BITS-1:0] right_val;

    assign occupied[i] = CW'(i) < count;

    if (i == 0) begin : g_head
      assign left_val = key;
    end else begin : g_mid
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = vals[i];
    end else begin : g_body
      assign right_val = vals[i+1];
    end

    sms_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occupied      (occupied[i]),
      .key           (key),
      .left_val      (left_val),
      .right_val     (right_val),
      .ins_before_in (ins_before[i]),
      .rem_found_in  (rem_found[i]),
      .ins_before_out(ins_before[i+1]),
      .rem_found_out (rem_found[i+1]),
      .match         (match[i]),
      .val           (vals[i])
    );
  end

  // status after the operation travels with the match flags
  assign size_wide     = (CW + 5)'(count_next);
  assign head.valid    = accept;
  assign head.kind     = in_data.kind;
  assign head.ins_ok   = ins_ok;
  assign head.rem_ok   = rem_ok;
  assign head.size_now = size_wide[4:0];
  assign head.is_empty = (count_next == '0);
  assign head.is_full  = (count_next >= CW'(CAPACITY));

  sms_tally #(
    .CAPACITY(CAPACITY)
  ) u_tally (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .flags    (match),
    .head     (head),
    .res_valid(out_valid),
    .res      (out_data)
  );

endmodule

/* hw/rtl/sms_checker.sv */
module sms_checker #(
  parameter int CAPACITY = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sms_pkg::out_item_t out_data
);
  import sms_pkg::*;

  `include "sorted_multiset_store_macros.svh"

  localparam logic [4:0] FULL_SIZE = 5'(CAPACITY);

  `SMS_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "held result changed")
  `SMS_CHECK(a_empty_fields, out_valid && out_data.is_empty |-> out_data.size_now == 5'd0 && out_data.occurrences == 5'd0 && !out_data.is_full, "empty store reports contents")
  `SMS_CHECK(a_full_size, out_valid && out_data.is_full |-> !out_data.is_empty && out_data.size_now == FULL_SIZE, "full flag disagrees with size")
  `SMS_CHECK(a_input_flows, !(out_valid && out_stall) |-> !in_stall, "input stalled while output can move")
  `SMS_CHECK_ALWAYS(a_reset_clears, rst |=> !out_valid, "result shown after reset")

endmodule

bind sorted_multiset_store sms_checker #(.CAPACITY(CAPACITY)) u_sms_checker (.*);
